FILE: hdl/cab_pkg.sv
// Shared types, constants and helpers for the clipped alpha blit unit.
// Used by the register file, the clip and blend pipelines and the top level.
package cab_pkg;

  localparam int ADDR_W = 4;
  localparam int SIZE_W = 13;
  localparam int COORD_W = 12;
  localparam logic [SIZE_W-1:0] MAX_SIZE = 13'd4096;
  localparam logic [SIZE_W-1:0] RESET_SIZE = 13'd512;
  localparam logic [7:0] FULL_ALPHA = 8'hff;

  localparam logic CMD_CLIP = 1'b0;
  localparam logic CMD_BLEND = 1'b1;

  typedef enum logic [1:0] {
    REG_SRC_W,
    REG_SRC_H,
    REG_DST_W,
    REG_DST_H
  } cab_reg_t;

  // surface sizes, already clamped to the largest usable size
  typedef struct packed {
    logic [SIZE_W-1:0] src_w;
    logic [SIZE_W-1:0] src_h;
    logic [SIZE_W-1:0] dst_w;
    logic [SIZE_W-1:0] dst_h;
  } cab_sizes_t;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic               nothing_drawn;
  } cab_clip_res_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] r);
    clamp_size = (r > MAX_SIZE) ? MAX_SIZE : r;
  endfunction

endpackage

FILE: hdl/cab_regs.sv
// APB register file holding the four surface sizes.
// Depends on cab_pkg for the register codes and the size struct.
module cab_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cab_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output cab_pkg::cab_sizes_t        sizes
);

  logic [cab_pkg::SIZE_W-1:0] src_w, src_h, dst_w, dst_h;
  logic [cab_pkg::SIZE_W-1:0] rd_val;
  cab_pkg::cab_reg_t          sel;
  logic                       wr;

  assign sel    = cab_pkg::cab_reg_t'(paddr[3:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= cab_pkg::RESET_SIZE;
      src_h <= cab_pkg::RESET_SIZE;
      dst_w <= cab_pkg::RESET_SIZE;
      dst_h <= cab_pkg::RESET_SIZE;
    end else if (wr) begin
      case (sel)
        cab_pkg::REG_SRC_W: src_w <= pwdata[cab_pkg::SIZE_W-1:0];
        cab_pkg::REG_SRC_H: src_h <= pwdata[cab_pkg::SIZE_W-1:0];
        cab_pkg::REG_DST_W: dst_w <= pwdata[cab_pkg::SIZE_W-1:0];
        cab_pkg::REG_DST_H: dst_h <= pwdata[cab_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      cab_pkg::REG_SRC_W: rd_val = src_w;
      cab_pkg::REG_SRC_H: rd_val = src_h;
      cab_pkg::REG_DST_W: rd_val = dst_w;
      cab_pkg::REG_DST_H: rd_val = dst_h;
      default:            rd_val = '0;
    endcase
  end

  assign prdata = {{(32-cab_pkg::SIZE_W){1'b0}}, rd_val};

  assign sizes.src_w = cab_pkg::clamp_size(src_w);
  assign sizes.src_h = cab_pkg::clamp_size(src_h);
  assign sizes.dst_w = cab_pkg::clamp_size(dst_w);
  assign sizes.dst_h = cab_pkg::clamp_size(dst_h);

endmodule

FILE: hdl/cab_clip.sv
// Four-stage rectangle clip pipeline: origin shift, offset apply,
// edge test and remaining span, then size clamp and empty check.
// Depends on cab_pkg for the size and result structs.
module cab_clip (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [15:0]    src_x,
  input  logic signed [15:0]    src_y,
  input  logic signed [15:0]    dst_x,
  input  logic signed [15:0]    dst_y,
  input  logic [14:0]           rect_width,
  input  logic [14:0]           rect_height,
  input  cab_pkg::cab_sizes_t   sizes,
  output logic                  out_valid,
  output cab_pkg::cab_clip_res_t res
);

  localparam int SW = cab_pkg::SIZE_W;

  // index 0 is the x axis, index 1 the y axis
  logic [1:0][SW-1:0] src_size, dst_size;

  logic               s1_valid;
  logic [1:0][15:0]   s1_s, s1_d, s1_m;
  logic [1:0][14:0]   s1_len;
  logic [1:0][15:0]   s1_m_next;

  logic               s2_valid;
  logic [1:0][15:0]   s2_s, s2_d;
  logic [1:0][16:0]   s2_len;
  logic [1:0][15:0]   s2_s_next, s2_d_next;
  logic [1:0][16:0]   s2_len_next;

  logic               s3_valid;
  logic [1:0]         s3_oor;
  logic [1:0][11:0]   s3_s, s3_d;
  logic [1:0][SW-1:0] s3_srem, s3_drem;
  logic [1:0][16:0]   s3_len;
  logic [1:0]         s3_oor_next;
  logic [1:0][SW-1:0] s3_srem_next, s3_drem_next;

  logic [1:0][SW-1:0] fin_len;
  logic               fin_empty;

  assign src_size[0] = sizes.src_w;
  assign src_size[1] = sizes.src_h;
  assign dst_size[0] = sizes.dst_w;
  assign dst_size[1] = sizes.dst_h;

  // stage 1: shift = -min(src, dst, 0) along each axis
  always_comb begin
    logic signed [15:0] lo_x, lo_y;
    lo_x = (src_x < dst_x) ? src_x : dst_x;
    lo_y = (src_y < dst_y) ? src_y : dst_y;
    s1_m_next[0] = (lo_x > 16'sd0) ? 16'd0 : lo_x;
    s1_m_next[1] = (lo_y > 16'sd0) ? 16'd0 : lo_y;
  end

  always_ff @(posedge clk) begin
    s1_s[0]   <= src_x;
    s1_s[1]   <= src_y;
    s1_d[0]   <= dst_x;
    s1_d[1]   <= dst_y;
    s1_len[0] <= rect_width;
    s1_len[1] <= rect_height;
    s1_m      <= s1_m_next;
  end

  // stage 2: apply the shift to both origins and the length
  always_comb begin
    logic [16:0] sd, dd;
    sd = '0;
    dd = '0;
    for (int a = 0; a < 2; a++) begin
      sd = {s1_s[a][15], s1_s[a]} - {s1_m[a][15], s1_m[a]};
      dd = {s1_d[a][15], s1_d[a]} - {s1_m[a][15], s1_m[a]};
      s2_s_next[a]   = sd[15:0];
      s2_d_next[a]   = dd[15:0];
      s2_len_next[a] = {2'b00, s1_len[a]} + {s1_m[a][15], s1_m[a]};
    end
  end

  always_ff @(posedge clk) begin
    s2_s   <= s2_s_next;
    s2_d   <= s2_d_next;
    s2_len <= s2_len_next;
  end

  // stage 3: origin beyond an edge, and span left up to each edge
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      s3_oor_next[a]  = (s2_s[a] >= {3'b000, src_size[a]}) |
                        (s2_d[a] >= {3'b000, dst_size[a]});
      s3_srem_next[a] = src_size[a] - s2_s[a][SW-1:0];
      s3_drem_next[a] = dst_size[a] - s2_d[a][SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s3_oor  <= s3_oor_next;
    s3_srem <= s3_srem_next;
    s3_drem <= s3_drem_next;
    s3_len  <= s2_len;
    for (int a = 0; a < 2; a++) begin
      s3_s[a] <= s2_s[a][11:0];
      s3_d[a] <= s2_d[a][11:0];
    end
  end

  // stage 4: clamp the length to both spans and flag an empty result
  always_comb begin
    logic [SW-1:0] span;
    logic          nonpos;
    span      = '0;
    nonpos    = 1'b0;
    fin_empty = s3_oor[0] | s3_oor[1];
    for (int a = 0; a < 2; a++) begin
      span   = (s3_srem[a] < s3_drem[a]) ? s3_srem[a] : s3_drem[a];
      nonpos = s3_len[a][16] | (s3_len[a] == 17'd0);
      fin_empty = fin_empty | nonpos;
      fin_len[a] = ($signed(s3_len[a]) < $signed({4'b0000, span})) ?
                   s3_len[a][SW-1:0] : span;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  // drive zeros on every position and size field unless a drawable clip result is present
  always_ff @(posedge clk) begin
    if (s3_valid && !fin_empty) begin
      res.src_x  <= s3_s[0];
      res.src_y  <= s3_s[1];
      res.dst_x  <= s3_d[0];
      res.dst_y  <= s3_d[1];
      res.width  <= fin_len[0];
      res.height <= fin_len[1];
    end else begin
      res.src_x  <= '0;
      res.src_y  <= '0;
      res.dst_x  <= '0;
      res.dst_y  <= '0;
      res.width  <= '0;
      res.height <= '0;
    end
    res.nothing_drawn <= s3_valid & fin_empty;
  end

endmodule

FILE: hdl/cab_blend.sv
// Four-stage alpha blend pipeline: channel difference, alpha multiply,
// divide by 255 through an add and shift, then add back to the destination.
// Depends on cab_pkg for the full-alpha constant.
module cab_blend (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] src_pixel,
  input  logic [31:0] dst_pixel,
  output logic        out_valid,
  output logic [31:0] blended_pixel
);

  logic            s1_valid, s2_valid, s3_valid;
  logic [2:0][7:0] s1_abs, s1_d, s2_d, s3_d;
  logic [2:0]      s1_neg, s2_neg, s3_neg;
  logic [7:0]      s1_a;
  logic [2:0][7:0] s1_abs_next;
  logic [2:0]      s1_neg_next;
  logic [2:0][15:0] s2_mag, s2_mag_next;
  logic [2:0][7:0]  s3_q, s3_q_next;
  logic [2:0][7:0]  fin_ch;
  logic [31:0]      s1_pass, s2_pass, s3_pass;
  logic             s1_full, s2_full, s3_full;

  // stage 1: signed difference per channel, kept as sign and magnitude
  always_comb begin
    logic [8:0] diff;
    diff = '0;
    for (int c = 0; c < 3; c++) begin
      diff = {1'b0, src_pixel[8*c +: 8]} - {1'b0, dst_pixel[8*c +: 8]};
      s1_neg_next[c] = diff[8];
      s1_abs_next[c] = diff[8] ? 8'(-diff) : diff[7:0];
    end
  end

  always_ff @(posedge clk) begin
    s1_abs  <= s1_abs_next;
    s1_neg  <= s1_neg_next;
    s1_a    <= src_pixel[31:24];
    s1_full <= (src_pixel[31:24] == cab_pkg::FULL_ALPHA);
    s1_pass <= {dst_pixel[31:24], src_pixel[23:0]};
    for (int c = 0; c < 3; c++) begin
      s1_d[c] <= dst_pixel[8*c +: 8];
    end
  end

  // stage 2: magnitude times alpha
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s2_mag_next[c] = s1_abs[c] * s1_a;
    end
  end

  always_ff @(posedge clk) begin
    s2_mag  <= s2_mag_next;
    s2_neg  <= s1_neg;
    s2_d    <= s1_d;
    s2_full <= s1_full;
    s2_pass <= s1_pass;
  end

  // stage 3: x / 255 = (x + 1 + (x >> 8)) >> 8, exact below 65280 in this 16-bit sum
  always_comb begin
    logic [15:0] sum;
    sum = '0;
    for (int c = 0; c < 3; c++) begin
      sum = s2_mag[c] + 16'd1 + {8'd0, s2_mag[c][15:8]};
      s3_q_next[c] = sum[15:8];
    end
  end

  always_ff @(posedge clk) begin
    s3_q    <= s3_q_next;
    s3_neg  <= s2_neg;
    s3_d    <= s2_d;
    s3_full <= s2_full;
    s3_pass <= s2_pass;
  end

  // stage 4: truncation toward zero falls out of dividing the magnitude
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      fin_ch[c] = s3_neg[c] ? (s3_d[c] - s3_q[c]) : (s3_d[c] + s3_q[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!s3_valid) begin
      blended_pixel <= '0;
    end else if (s3_full) begin
      blended_pixel <= s3_pass;
    end else begin
      blended_pixel <= {s3_pass[31:24], fin_ch[2], fin_ch[1], fin_ch[0]};
    end
  end

endmodule

FILE: hdl/clipped_alpha_blit_unit.sv
// Clipped alpha blit unit: rectangle clip and BGRA pixel blend commands.
// Each transaction is registered through the pipeline stages before done rises.
// Throughput one transaction per cycle, set by the four-stage pipelines.
// busy stays low; the receiver cannot stall, so results stream out unheld.
// Synchronous reset clears the pipeline valid bits and sets sizes to 512.
module clipped_alpha_blit_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cab_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       start,
  output logic                       busy,
  input  logic                       command,
  input  logic signed [15:0]         src_x,
  input  logic signed [15:0]         src_y,
  input  logic signed [15:0]         dst_x,
  input  logic signed [15:0]         dst_y,
  input  logic [14:0]                rect_width,
  input  logic [14:0]                rect_height,
  input  logic [31:0]                src_pixel,
  input  logic [31:0]                dst_pixel,
  output logic                       done,
  output logic [11:0]                clip_src_x,
  output logic [11:0]                clip_src_y,
  output logic [11:0]                clip_dst_x,
  output logic [11:0]                clip_dst_y,
  output logic [12:0]                clip_width,
  output logic [12:0]                clip_height,
  output logic                       nothing_drawn,
  output logic [31:0]                blended_pixel
);

  cab_pkg::cab_sizes_t    sizes;
  cab_pkg::cab_clip_res_t clip_res;
  logic                   take;
  logic                   clip_valid, blend_valid;

  assign busy = 1'b0;
  assign take = start & ~busy;

  cab_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sizes   (sizes)
  );

  cab_clip u_clip (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (take && (command == cab_pkg::CMD_CLIP)),
    .src_x       (src_x),
    .src_y       (src_y),
    .dst_x       (dst_x),
    .dst_y       (dst_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .sizes       (sizes),
    .out_valid   (clip_valid),
    .res         (clip_res)
  );

  cab_blend u_blend (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (take && (command == cab_pkg::CMD_BLEND)),
    .src_pixel     (src_pixel),
    .dst_pixel     (dst_pixel),
    .out_valid     (blend_valid),
    .blended_pixel (blended_pixel)
  );

  assign done          = clip_valid | blend_valid;
  assign clip_src_x    = clip_res.src_x;
  assign clip_src_y    = clip_res.src_y;
  assign clip_dst_x    = clip_res.dst_x;
  assign clip_dst_y    = clip_res.dst_y;
  assign clip_width    = clip_res.width;
  assign clip_height   = clip_res.height;
  assign nothing_drawn = clip_res.nothing_drawn;

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 4))
    else $error("result without a transaction four cycles earlier");

  a_one_pipe_only: assert property (@(posedge clk) disable iff (rst)
    !(clip_valid && blend_valid))
    else $error("clip and blend results in the same cycle");

  a_empty_zero_size: assert property (@(posedge clk) disable iff (rst)
    nothing_drawn |-> (clip_width == 13'd0 && clip_height == 13'd0 &&
                       blended_pixel == 32'd0))
    else $error("empty clip with non-zero fields");

  a_size_pair: assert property (@(posedge clk) disable iff (rst)
    (clip_width != 13'd0) |-> (clip_height != 13'd0 && clip_valid))
    else $error("width without height or outside a clip result");

endmodule

FILE: dv/clipped_alpha_blit_unit_test.sv
// Self-checking testbench for clipped_alpha_blit_unit: clip and blend commands
// are predicted in SystemVerilog and compared with each strobed result.
// Depends on cab_pkg and the clipped_alpha_blit_unit RTL only.
module clipped_alpha_blit_unit_test;

  localparam int ALPHA_SCALE = 255;
  localparam int DRAIN_CYCLES = 8;
  localparam int SIZE_W = cab_pkg::SIZE_W;
  localparam int ADDR_W = cab_pkg::ADDR_W;

  typedef struct {
    logic               command;
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic [14:0]        rect_width;
    logic [14:0]        rect_height;
    logic [31:0]        src_pixel;
    logic [31:0]        dst_pixel;
  } blit_cmd_t;

  typedef struct {
    logic [11:0] clip_src_x;
    logic [11:0] clip_src_y;
    logic [11:0] clip_dst_x;
    logic [11:0] clip_dst_y;
    logic [12:0] clip_width;
    logic [12:0] clip_height;
    logic        nothing_drawn;
    logic [31:0] blended_pixel;
  } blit_res_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic               command = cab_pkg::CMD_CLIP;
  logic signed [15:0] src_x = '0;
  logic signed [15:0] src_y = '0;
  logic signed [15:0] dst_x = '0;
  logic signed [15:0] dst_y = '0;
  logic [14:0]        rect_width = '0;
  logic [14:0]        rect_height = '0;
  logic [31:0]        src_pixel = '0;
  logic [31:0]        dst_pixel = '0;
  logic               done;
  logic [11:0]        clip_src_x;
  logic [11:0]        clip_src_y;
  logic [11:0]        clip_dst_x;
  logic [11:0]        clip_dst_y;
  logic [12:0]        clip_width;
  logic [12:0]        clip_height;
  logic               nothing_drawn;
  logic [31:0]        blended_pixel;

  // shadow copy of the surface size registers
  logic [SIZE_W-1:0] surf_src_w = cab_pkg::RESET_SIZE;
  logic [SIZE_W-1:0] surf_src_h = cab_pkg::RESET_SIZE;
  logic [SIZE_W-1:0] surf_dst_w = cab_pkg::RESET_SIZE;
  logic [SIZE_W-1:0] surf_dst_h = cab_pkg::RESET_SIZE;

  blit_res_t expected_blits[$];
  blit_res_t oldest_blit;
  int        mismatch_count = 0;
  int        burst_left = 0;

  clipped_alpha_blit_unit i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int eff_size(logic [SIZE_W-1:0] r);
    return (r > cab_pkg::MAX_SIZE) ? int'(cab_pkg::MAX_SIZE) : int'(r);
  endfunction

  function automatic blit_res_t predict_blit(blit_cmd_t c);
    blit_res_t r;
    longint    sx, sy, dx, dy, w, h, sw, sh, dw, dh;
    logic [7:0] a;
    int        diff, q;
    r = '{default: '0};
    if (c.command == cab_pkg::CMD_BLEND) begin
      a = c.src_pixel[31:24];
      r.blended_pixel[31:24] = c.dst_pixel[31:24];
      if (a == cab_pkg::FULL_ALPHA) begin
        r.blended_pixel[23:0] = c.src_pixel[23:0];
      end else begin
        for (int k = 0; k < 3; k++) begin
          diff = int'(c.src_pixel[8*k +: 8]) - int'(c.dst_pixel[8*k +: 8]);
          q = diff * int'(a) / ALPHA_SCALE;
          r.blended_pixel[8*k +: 8] = 8'(int'(c.dst_pixel[8*k +: 8]) + q);
        end
      end
      return r;
    end
    sx = c.src_x;
    sy = c.src_y;
    dx = c.dst_x;
    dy = c.dst_y;
    w = c.rect_width;
    h = c.rect_height;
    sw = eff_size(surf_src_w);
    sh = eff_size(surf_src_h);
    dw = eff_size(surf_dst_w);
    dh = eff_size(surf_dst_h);
    // pull negative origins to zero, dragging the other origin along
    if (sx < 0) begin w += sx; dx -= sx; sx = 0; end
    if (sy < 0) begin h += sy; dy -= sy; sy = 0; end
    if (dx < 0) begin w += dx; sx -= dx; dx = 0; end
    if (dy < 0) begin h += dy; sy -= dy; dy = 0; end
    if (sx >= sw || sy >= sh || dx >= dw || dy >= dh) begin
      r.nothing_drawn = 1'b1;
      return r;
    end
    if (sw - sx < w) w = sw - sx;
    if (sh - sy < h) h = sh - sy;
    if (dw - dx < w) w = dw - dx;
    if (dh - dy < h) h = dh - dy;
    if (w <= 0 || h <= 0) begin
      r.nothing_drawn = 1'b1;
      return r;
    end
    r.clip_src_x = 12'(sx);
    r.clip_src_y = 12'(sy);
    r.clip_dst_x = 12'(dx);
    r.clip_dst_y = 12'(dy);
    r.clip_width = 13'(w);
    r.clip_height = 13'(h);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // take each strobed result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_blits.size() == 0) begin
        $error("result transaction with no prediction waiting");
        mismatch_count++;
      end else begin
        oldest_blit = expected_blits.pop_front();
        check_field("clip_src_x", 32'(oldest_blit.clip_src_x), 32'(clip_src_x));
        check_field("clip_src_y", 32'(oldest_blit.clip_src_y), 32'(clip_src_y));
        check_field("clip_dst_x", 32'(oldest_blit.clip_dst_x), 32'(clip_dst_x));
        check_field("clip_dst_y", 32'(oldest_blit.clip_dst_y), 32'(clip_dst_y));
        check_field("clip_width", 32'(oldest_blit.clip_width), 32'(clip_width));
        check_field("clip_height", 32'(oldest_blit.clip_height), 32'(clip_height));
        check_field("nothing_drawn", 32'(oldest_blit.nothing_drawn),
                    32'(nothing_drawn));
        check_field("blended_pixel", oldest_blit.blended_pixel, blended_pixel);
      end
    end
  end

  task automatic send_blit(blit_cmd_t c);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command <= c.command;
    src_x <= c.src_x;
    src_y <= c.src_y;
    dst_x <= c.dst_x;
    dst_y <= c.dst_y;
    rect_width <= c.rect_width;
    rect_height <= c.rect_height;
    src_pixel <= c.src_pixel;
    dst_pixel <= c.dst_pixel;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_blits.push_back(predict_blit(c));
  endtask

  // hold the sender until every result is back and the pipeline is empty
  task automatic drain_blits();
    start <= 1'b0;
    while (expected_blits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(cab_pkg::cab_reg_t which, logic [SIZE_W-1:0] value);
    logic [31:0] data;
    data = {19'($urandom()), value};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (which)
      cab_pkg::REG_SRC_W: surf_src_w = data[SIZE_W-1:0];
      cab_pkg::REG_SRC_H: surf_src_h = data[SIZE_W-1:0];
      cab_pkg::REG_DST_W: surf_dst_w = data[SIZE_W-1:0];
      cab_pkg::REG_DST_H: surf_dst_h = data[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_sizes(int sw, int sh, int dw, int dh);
    drain_blits();
    write_size(cab_pkg::REG_SRC_W, SIZE_W'(sw));
    write_size(cab_pkg::REG_SRC_H, SIZE_W'(sh));
    write_size(cab_pkg::REG_DST_W, SIZE_W'(dw));
    write_size(cab_pkg::REG_DST_H, SIZE_W'(dh));
  endtask

  function automatic blit_cmd_t make_clip(int sx, int sy, int dx, int dy, int w, int h);
    blit_cmd_t c;
    c.command = cab_pkg::CMD_CLIP;
    c.src_x = 16'(sx);
    c.src_y = 16'(sy);
    c.dst_x = 16'(dx);
    c.dst_y = 16'(dy);
    c.rect_width = 15'(w);
    c.rect_height = 15'(h);
    c.src_pixel = $urandom();
    c.dst_pixel = $urandom();
    return c;
  endfunction

  function automatic blit_cmd_t make_blend(logic [31:0] s, logic [31:0] d);
    blit_cmd_t c;
    c = make_clip($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    c.command = cab_pkg::CMD_BLEND;
    c.src_pixel = s;
    c.dst_pixel = d;
    return c;
  endfunction

  // mostly near the surfaces so that edges are hit, sometimes anywhere
  function automatic int rand_coord(int lim);
    if ($urandom_range(0, 3) == 0) return $urandom();
    return int'($urandom_range(0, lim + 64)) - 32;
  endfunction

  function automatic int rand_extent(int lim);
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 32767);
    return $urandom_range(0, lim + 32);
  endfunction

  function automatic int rand_surface();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 64);
      1: return $urandom_range(1, 4096);
      2: return $urandom_range(0, 8191);
      default: return ($urandom_range(0, 1) != 0) ? 4096 : $urandom_range(1, 2);
    endcase
  endfunction

  task automatic run_random(int count);
    int lim;
    logic [31:0] s;
    lim = eff_size(surf_src_w);
    if (eff_size(surf_src_h) > lim) lim = eff_size(surf_src_h);
    if (eff_size(surf_dst_w) > lim) lim = eff_size(surf_dst_w);
    if (eff_size(surf_dst_h) > lim) lim = eff_size(surf_dst_h);
    repeat (count) begin
      if ($urandom_range(0, 1) == 0) begin
        send_blit(make_clip(rand_coord(lim), rand_coord(lim), rand_coord(lim),
                            rand_coord(lim), rand_extent(lim), rand_extent(lim)));
      end else begin
        s = $urandom();
        case ($urandom_range(0, 5))
          0: s[31:24] = cab_pkg::FULL_ALPHA;
          1: s[31:24] = 8'h00;
          default: ;
        endcase
        send_blit(make_blend(s, $urandom()));
      end
    end
  endtask

  task automatic test_clip_directed();
    send_blit(make_clip(0, 0, 0, 0, 512, 512));
    send_blit(make_clip(0, 0, 0, 0, 0, 5));
    send_blit(make_clip(-10, 0, 0, 0, 100, 50));
    send_blit(make_clip(0, -7, 0, -3, 20, 20));
    send_blit(make_clip(0, 0, -32768, 0, 32767, 32767));
    send_blit(make_clip(-32768, -32768, -32768, -32768, 32767, 32767));
    send_blit(make_clip(32767, 32767, 32767, 32767, 32767, 32767));
    send_blit(make_clip(511, 511, 511, 511, 32767, 32767));
    send_blit(make_clip(512, 0, 0, 0, 10, 10));
    send_blit(make_clip(0, 0, 0, 512, 10, 10));
    send_blit(make_clip(0, 0, 500, 0, 100, 1));
    send_blit(make_clip(100, 0, -50, 0, 40, 10));
  endtask

  task automatic test_blend_directed();
    send_blit(make_blend(32'hff112233, 32'h80aabbcc));
    send_blit(make_blend(32'h00112233, 32'h80aabbcc));
    send_blit(make_blend(32'h80ff00ff, 32'h1200ff00));
    send_blit(make_blend(32'hfeffffff, 32'h00000000));
    send_blit(make_blend(32'h01000000, 32'hffffffff));
    send_blit(make_blend(32'hffffffff, 32'hffffffff));
    send_blit(make_blend(32'h00000000, 32'h00000000));
    send_blit(make_blend(32'h7f804020, 32'haa204080));
  endtask

  task automatic test_default_sizes();
    run_random(240);
  endtask

  task automatic test_size_extremes();
    apply_sizes(1, 1, 1, 1);
    run_random(200);
    apply_sizes(4096, 4096, 4096, 4096);
    run_random(240);
    // sizes beyond the largest surface act as the largest
    apply_sizes(8191, 8191, 8191, 8191);
    run_random(200);
    apply_sizes(0, 0, 0, 0);
    run_random(160);
    apply_sizes(0, 512, 4096, 8191);
    run_random(200);
  endtask

  task automatic test_mixed_sizes();
    repeat (4) begin
      apply_sizes(rand_surface(), rand_surface(), rand_surface(), rand_surface());
      run_random(160);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_clip_directed();
    test_blend_directed();
    test_default_sizes();
    test_size_extremes();
    test_mixed_sizes();
    drain_blits();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
hdl/cab_pkg.sv
hdl/cab_regs.sv
hdl/cab_clip.sv
hdl/cab_blend.sv
hdl/clipped_alpha_blit_unit.sv
dv/clipped_alpha_blit_unit_test.sv
